// ===== rtl/first_fit_block_allocator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit_defines
// Assertion macros used by the allocator top-level RTL.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define FFBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Constants, item types and control/status bundles of the block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

    localparam int POOL_BLOCKS     = 1024;
    localparam int BLOCK_BYTES     = 512;
    localparam int RESERVED_BLOCKS = 16;

    localparam int ADDR_W      = 32;
    localparam int BLK_W       = $clog2(POOL_BLOCKS);
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int ROW_BLOCKS  = 8;
    localparam int POS_W       = $clog2(ROW_BLOCKS);
    localparam int NUM_ROWS    = POOL_BLOCKS / ROW_BLOCKS;
    localparam int ROW_W       = BLK_W - POS_W;
    localparam int CNT_W       = BLK_W + 1;

    localparam logic [ADDR_W-1:0] POOL_BASE_RESET = 32'h0010_0000;

    // block states
    localparam logic [1:0] ST_FREE = 2'd0;
    localparam logic [1:0] ST_USED = 2'd1;
    localparam logic [1:0] ST_RSRV = 2'd2;

    // commands
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // result status
    localparam logic [2:0] RS_OK      = 3'd0;
    localparam logic [2:0] RS_ZERO    = 3'd1;
    localparam logic [2:0] RS_NOSPACE = 3'd2;
    localparam logic [2:0] RS_IGNORED = 3'd3;
    localparam logic [2:0] RS_CORRUPT = 3'd4;
    localparam logic [2:0] RS_OUTPOOL = 3'd5;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] size_bytes;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [ADDR_W-1:0] result_address;
        logic              in_use;
    } rsp_t;

    // one memory row: end marks and states of ROW_BLOCKS blocks
    typedef struct packed {
        logic [ROW_BLOCKS-1:0]      endm;
        logic [ROW_BLOCKS-1:0][1:0] st;
    } row_t;

    typedef struct packed {
        logic       load;
        logic       clr_wr;
        logic       row_zero;
        logic       row_inc;
        logic       row_next;
        logic       row_hit;
        logic       rd;
        logic       run_clr;
        logic       run_upd;
        logic       mark_wr;
        logic       free_wr;
        logic       fin;
        logic [2:0] fin_status;
    } ctl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       size_zero;
        logic       too_big;
        logic       out_pool;
        logic       row_last;
        logic       data_last;
        logic       hit;
        logic       mark_last;
        logic       free_bad_first;
        logic       free_done;
        logic       free_corrupt;
        logic       can_fin;
    } sts_t;

    function automatic row_t reset_row(input logic [ROW_W-1:0] row);
        row_t r;
        int   idx;
        for (int k = 0; k < ROW_BLOCKS; k++)
        begin
            idx       = int'(row) * ROW_BLOCKS + k;
            r.st[k]   = (idx < RESERVED_BLOCKS) ? ST_RSRV : ST_FREE;
            r.endm[k] = (idx < RESERVED_BLOCKS - 1) ? 1'b0 : 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/first_fit_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit allocator over a pool of fixed-size blocks with reserved head.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   ffba_pkg::req_t
//   rsp      out        rsp_valid/rsp_stall   ffba_pkg::rsp_t
//   cfg      in         cfg_we                cfg_wdata (pool base)
//
// One item at a time; the table is held as 128 rows of eight blocks.
// Allocate: scan of up to 128 rows, then a read and a write per row of the run.
// Free: a read and a write per row walked. Query and rejected requests go from
// dispatch to the result. After reset a clearing pass runs with req_stall high.
// rsp is registered; a new item is taken while a result waits on rsp_stall,
// and its result is held back until that one leaves.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_block_allocator_unit_defines.svh"

module first_fit_block_allocator_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire ffba_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output ffba_pkg::rsp_t     rsp,
    input  wire logic          cfg_we,
    input  wire logic [31:0]   cfg_wdata
);

    import ffba_pkg::*;

    ctl_t ctl;
    sts_t sts;

    ffba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    ffba_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .sts       (sts)
    );

    `FFBA_ASSERT_NEXT(a_one_item, clk, rst_n, req_valid && !req_stall, req_stall, "item taken while busy")
    `FFBA_ASSERT_NOW(a_status_range, clk, rst_n, rsp_valid, rsp.status <= RS_OUTPOOL, "bad status")
    `FFBA_ASSERT_NOW(a_addr_ok_only, clk, rst_n, rsp_valid && rsp.status != RS_OK, rsp.result_address == '0, "address on failure")
    `FFBA_ASSERT_NOW(a_use_ok_only, clk, rst_n, rsp_valid && rsp.in_use, rsp.status == RS_OK, "in-use flag on failure")

endmodule

`default_nettype wire

// ===== rtl/ffba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer: clearing pass, command dispatch, scan, mark, free walk, result.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire ffba_pkg::sts_t sts,
    output ffba_pkg::ctl_t     ctl
);

    import ffba_pkg::*;

    localparam logic [3:0] S_CLEAR      = 4'd0;
    localparam logic [3:0] S_IDLE       = 4'd1;
    localparam logic [3:0] S_DISP       = 4'd2;
    localparam logic [3:0] S_SCAN_RD    = 4'd3;
    localparam logic [3:0] S_SCAN       = 4'd4;
    localparam logic [3:0] S_MARK_RD    = 4'd5;
    localparam logic [3:0] S_MARK_WR    = 4'd6;
    localparam logic [3:0] S_FREE_FIRST = 4'd7;
    localparam logic [3:0] S_FREE_RD    = 4'd8;
    localparam logic [3:0] S_FREE_NEXT  = 4'd9;
    localparam logic [3:0] S_FIN        = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [2:0] stat_reg;
    logic [2:0] stat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            stat_reg  <= RS_OK;
        end
        else
        begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        stat_next  = stat_reg;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_wr  = 1'b1;
                ctl.row_inc = 1'b1;
                if (sts.row_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (sts.cmd)
                    CMD_ALLOC:
                    begin
                        if (sts.size_zero)
                        begin
                            stat_next  = RS_ZERO;
                            state_next = S_FIN;
                        end
                        else if (sts.too_big)
                        begin
                            stat_next  = RS_NOSPACE;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            ctl.row_zero = 1'b1;
                            ctl.run_clr  = 1'b1;
                            state_next   = S_SCAN_RD;
                        end
                    end
                    CMD_FREE:
                    begin
                        if (sts.out_pool)
                        begin
                            stat_next  = RS_OUTPOOL;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            ctl.rd     = 1'b1;
                            state_next = S_FREE_FIRST;
                        end
                    end
                    CMD_QUERY:
                    begin
                        if (sts.out_pool)
                        begin
                            stat_next = RS_OUTPOOL;
                        end
                        else
                        begin
                            ctl.rd    = 1'b1;
                            stat_next = RS_OK;
                        end
                        state_next = S_FIN;
                    end
                    default:
                    begin
                        stat_next  = RS_OK;
                        state_next = S_FIN;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                ctl.rd      = 1'b1;
                ctl.row_inc = 1'b1;
                state_next  = S_SCAN;
            end
            S_SCAN:
            begin
                if (sts.hit)
                begin
                    ctl.row_hit = 1'b1;
                    state_next  = S_MARK_RD;
                end
                else if (sts.data_last)
                begin
                    stat_next  = RS_NOSPACE;
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.run_upd = 1'b1;
                    ctl.rd      = 1'b1;
                    ctl.row_inc = 1'b1;
                end
            end
            S_MARK_RD:
            begin
                ctl.rd     = 1'b1;
                state_next = S_MARK_WR;
            end
            S_MARK_WR:
            begin
                ctl.mark_wr = 1'b1;
                if (sts.mark_last)
                begin
                    stat_next  = RS_OK;
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.row_inc = 1'b1;
                    state_next  = S_MARK_RD;
                end
            end
            S_FREE_FIRST, S_FREE_NEXT:
            begin
                if (state_reg == S_FREE_FIRST && sts.free_bad_first)
                begin
                    stat_next  = RS_IGNORED;
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.free_wr = 1'b1;
                    if (sts.free_done)
                    begin
                        stat_next  = RS_OK;
                        state_next = S_FIN;
                    end
                    else if (sts.free_corrupt || sts.data_last)
                    begin
                        stat_next  = RS_CORRUPT;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ctl.row_next = 1'b1;
                        state_next   = S_FREE_RD;
                    end
                end
            end
            S_FREE_RD:
            begin
                ctl.rd     = 1'b1;
                state_next = S_FREE_NEXT;
            end
            S_FIN:
            begin
                if (sts.can_fin)
                begin
                    ctl.fin        = 1'b1;
                    ctl.fin_status = stat_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ffba_dpath.sv =====
// ----------------------------------------------------------------------------
// ffba_dpath
// Block table memory (rows of eight blocks), row scan, run marking,
// free walk, address mapping and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_dpath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ffba_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output ffba_pkg::rsp_t     rsp,
    input  wire logic          cfg_we,
    input  wire logic [31:0]   cfg_wdata,
    input  wire ffba_pkg::ctl_t ctl,
    output ffba_pkg::sts_t     sts
);

    import ffba_pkg::*;

    row_t              mem [NUM_ROWS];
    row_t              rdata_reg;
    logic [ROW_W-1:0]  data_row_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [ADDR_W-1:0] pool_base_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    rsp_t              rsp_reg;

    logic [1:0]        cmd_reg;
    logic              zero_reg;
    logic              big_reg;
    logic              oop_reg;
    logic [CNT_W-1:0]  needed_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [BLK_W-1:0]  end_reg;
    logic [CNT_W-1:0]  run_reg;

    // request decode
    logic [ADDR_W:0]   size_sum;
    logic [ADDR_W:0]   needed_full;
    logic [ADDR_W-1:0] offset;
    logic              oop_in;
    logic [BLK_W-1:0]  blk_in;

    assign size_sum    = {1'b0, req.size_bytes} + (ADDR_W+1)'(BLOCK_BYTES - 1);
    assign needed_full = size_sum >> BLOCK_SHIFT;
    assign offset      = req.address - pool_base_reg;
    assign oop_in      = (req.address < pool_base_reg)
                      || ((offset >> (BLOCK_SHIFT + BLK_W)) != '0);
    assign blk_in      = offset[BLOCK_SHIFT +: BLK_W];

    // first-fit scan over one row
    logic [CNT_W-1:0] run_cur;
    logic             hit;
    logic [POS_W-1:0] hit_pos;
    logic [BLK_W-1:0] hit_end;
    logic [CNT_W-1:0] hit_start;

    always_comb
    begin
        run_cur = run_reg;
        hit     = 1'b0;
        hit_pos = '0;
        for (int k = 0; k < ROW_BLOCKS; k++)
        begin
            if (rdata_reg.st[k] == ST_FREE)
            begin
                run_cur = run_cur + 1'b1;
                if (!hit && run_cur >= needed_reg)
                begin
                    hit     = 1'b1;
                    hit_pos = POS_W'(k);
                end
            end
            else
            begin
                run_cur = '0;
            end
        end
    end

    assign hit_end   = {data_row_reg, hit_pos};
    assign hit_start = {1'b0, hit_end} + 1'b1 - needed_reg;

    // run marking
    row_t marked_row;

    always_comb
    begin
        marked_row = rdata_reg;
        for (int k = 0; k < ROW_BLOCKS; k++)
        begin
            if ({data_row_reg, POS_W'(k)} >= blk_reg && {data_row_reg, POS_W'(k)} <= end_reg)
            begin
                marked_row.st[k]   = ST_USED;
                marked_row.endm[k] = ({data_row_reg, POS_W'(k)} == end_reg);
            end
        end
    end

    // free walk over one row, starting at blk_reg's position
    logic [POS_W-1:0] fpos;
    logic             going;
    logic             free_done;
    logic             free_corrupt;
    row_t             freed_row;

    assign fpos = blk_reg[POS_W-1:0];

    always_comb
    begin
        going        = 1'b1;
        free_done    = 1'b0;
        free_corrupt = 1'b0;
        freed_row    = rdata_reg;
        for (int k = 0; k < ROW_BLOCKS; k++)
        begin
            if (POS_W'(k) >= fpos && going)
            begin
                if (rdata_reg.st[k] != ST_USED)
                begin
                    free_corrupt = 1'b1;
                    going        = 1'b0;
                end
                else
                begin
                    freed_row.st[k] = ST_FREE;
                    if (rdata_reg.endm[k])
                    begin
                        free_done = 1'b1;
                        going     = 1'b0;
                    end
                end
            end
        end
    end

    // memory
    logic             wr_en;
    logic [ROW_W-1:0] wr_addr;
    row_t             wr_data;

    always_comb
    begin
        wr_en   = ctl.clr_wr | ctl.mark_wr | ctl.free_wr;
        wr_addr = data_row_reg;
        wr_data = freed_row;
        if (ctl.clr_wr)
        begin
            wr_addr = row_reg;
            wr_data = reset_row(row_reg);
        end
        else if (ctl.mark_wr)
        begin
            wr_data = marked_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd)
        begin
            rdata_reg    <= mem[row_reg];
            data_row_reg <= row_reg;
        end
    end

    // row pointer and control registers
    always_comb
    begin
        row_next = row_reg;
        if (ctl.load)
        begin
            row_next = blk_in[BLK_W-1:POS_W];
        end
        else if (ctl.row_zero)
        begin
            row_next = '0;
        end
        else if (ctl.row_hit)
        begin
            row_next = hit_start[BLK_W-1:POS_W];
        end
        else if (ctl.row_next)
        begin
            row_next = data_row_reg + 1'b1;
        end
        else if (ctl.row_inc)
        begin
            row_next = row_reg + 1'b1;
        end
    end

    assign out_valid_next = ctl.fin ? 1'b1 : (out_valid_reg & rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            pool_base_reg <= POOL_BASE_RESET;
        end
        else
        begin
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                pool_base_reg <= cfg_wdata;
            end
        end
    end

    // item registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= req.cmd;
            zero_reg   <= (req.size_bytes == '0);
            big_reg    <= (needed_full > (ADDR_W+1)'(POOL_BLOCKS));
            oop_reg    <= oop_in;
            needed_reg <= needed_full[CNT_W-1:0];
            blk_reg    <= blk_in;
        end
        else if (ctl.row_hit)
        begin
            blk_reg <= hit_start[BLK_W-1:0];
            end_reg <= hit_end;
        end
        else if (ctl.row_next)
        begin
            blk_reg <= {data_row_reg + 1'b1, POS_W'(0)};
        end

        if (ctl.run_clr)
        begin
            run_reg <= '0;
        end
        else if (ctl.run_upd)
        begin
            run_reg <= run_cur;
        end

        if (ctl.fin)
        begin
            rsp_reg.status         <= ctl.fin_status;
            rsp_reg.result_address <= (cmd_reg == CMD_ALLOC && ctl.fin_status == RS_OK)
                ? pool_base_reg + ADDR_W'({blk_reg, {BLOCK_SHIFT{1'b0}}})
                : '0;
            rsp_reg.in_use         <= (cmd_reg == CMD_QUERY && ctl.fin_status == RS_OK)
                && (rdata_reg.st[fpos] != ST_FREE);
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        sts.cmd            = cmd_reg;
        sts.size_zero      = zero_reg;
        sts.too_big        = big_reg;
        sts.out_pool       = oop_reg;
        sts.row_last       = (row_reg == ROW_W'(NUM_ROWS - 1));
        sts.data_last      = (data_row_reg == ROW_W'(NUM_ROWS - 1));
        sts.hit            = hit;
        sts.mark_last      = (data_row_reg == end_reg[BLK_W-1:POS_W]);
        sts.free_bad_first = (rdata_reg.st[fpos] != ST_USED);
        sts.free_done      = free_done;
        sts.free_corrupt   = free_corrupt;
        sts.can_fin        = !out_valid_reg || !rsp_stall;
    end

endmodule

`default_nettype wire
